[rtl/rcch_pkg.sv]
// ----------------------------------------------------------------------------
// rcch_pkg
// Shared types and constants of the grid raycaster column core.
// ----------------------------------------------------------------------------
package rcch_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PLAYER_X      = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y      = 3'd1;
  localparam logic [2:0] REG_VIEW_ANGLE    = 3'd2;
  localparam logic [2:0] REG_FIELD_OF_VIEW = 3'd3;
  localparam logic [2:0] REG_RAY_COUNT     = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam int CFG_DATA_W = 16;

  // sine unit operand select
  localparam logic [1:0] SEL_COS = 2'd0;
  localparam logic [1:0] SEL_SIN = 2'd1;
  localparam logic [1:0] SEL_FIX = 2'd2;

  // divider operand select
  localparam logic DIV_ANGLE  = 1'b0;
  localparam logic DIV_HEIGHT = 1'b1;

  // divider numerator width: screen_height * 163840 fits 29 bits
  localparam int DIV_NUM_W = 29;
  localparam int HEIGHT_SCALE = 163840;
  localparam logic [11:0] HEIGHT_MAX = 12'd4095;

  // quarter-wave polynomial, Horner coefficients in Q30
  localparam logic [31:0] POLY_SEED = 32'd172272;
  localparam logic [31:0] POLY_C [4] = '{32'd5026995, 32'd85569306,
                                         32'd693598668, 32'd1686629713};

  typedef struct packed {
    logic       in_ready;
    logic       clr_en;
    logic       map_wr;
    logic       item_latch;
    logic       div_start;
    logic       div_sel;
    logic       ang_load;
    logic       sine_start;
    logic [1:0] sine_sel;
    logic       sine_store;
    logic       march_init;
    logic       march_rd;
    logic       march_adv;
    logic       hit_store;
    logic       miss_store;
    logic       den_load;
    logic       ht_div_load;
    logic       ht_sat;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic clear_last;
    logic div_done;
    logic sine_done;
    logic wall;
    logic last_step;
    logic den_pos;
    logic out_free;
  } stat_t;

endpackage

[rtl/rcch_in_if.sv]
// ----------------------------------------------------------------------------
// rcch_in_if
// Input item channel: map cell writes and ray casts.
// ----------------------------------------------------------------------------
interface rcch_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] cell_x;
  logic [3:0] cell_y;
  logic       cell_wall;
  logic [9:0] ray_index;

  modport source (output valid, mode, cell_x, cell_y, cell_wall, ray_index,
                  input ready);
  modport sink (input valid, mode, cell_x, cell_y, cell_wall, ray_index,
                output ready);
endinterface

[rtl/rcch_out_if.sv]
// ----------------------------------------------------------------------------
// rcch_out_if
// Result channel: one wall column per cast ray.
// ----------------------------------------------------------------------------
interface rcch_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  column_index;
  logic        wall_hit;
  logic [7:0]  hit_steps;
  logic [3:0]  hit_cell_x;
  logic [3:0]  hit_cell_y;
  logic [11:0] wall_height;
  logic [10:0] first_row;
  logic [10:0] end_row;

  modport source (output valid, column_index, wall_hit, hit_steps, hit_cell_x,
                  hit_cell_y, wall_height, first_row, end_row, input ready);
  modport sink (input valid, column_index, wall_hit, hit_steps, hit_cell_x,
                hit_cell_y, wall_height, first_row, end_row, output ready);
endinterface

[rtl/rcch_sine.sv]
// ----------------------------------------------------------------------------
// rcch_sine
// Multi-cycle Q14 sine: quadrant fold, Horner polynomial on one multiplier.
// ----------------------------------------------------------------------------
module rcch_sine #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [15:0] value
);

  localparam int PH_STEP = 65536 / SINE_TABLE_SIZE;
  localparam logic [15:0] PH_MASK = 16'(65536 - PH_STEP);
  localparam logic [31:0] POLY_SEED_L = rcch_pkg::POLY_SEED;

  logic        busy;
  logic [2:0]  step;
  logic        neg;
  logic [14:0] rr;
  logic [30:0] z2;
  logic [31:0] s;
  logic [31:0] op_a;
  logic [30:0] op_b;
  logic [62:0] prod;
  logic [15:0] phase;
  logic [16:0] rounded;

  assign phase   = angle & PH_MASK;
  assign op_a    = (step == 3'd0) ? 32'(rr) : s;
  assign op_b    = (step == 3'd0 || step == 3'd5) ? 31'(rr) : z2;
  assign prod    = 63'(op_a) * 63'(op_b);
  assign rounded = 17'((33'(s) + 33'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        if (step == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= phase[15];
      rr  <= phase[14] ? 15'(15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
    end else if (busy) begin
      case (step)
        3'd0: begin
          z2 <= 31'(prod << 2);
          s  <= POLY_SEED_L;
        end
        3'd1, 3'd2, 3'd3, 3'd4: s <= rcch_pkg::POLY_C[2'(step - 3'd1)] - 32'(prod >> 30);
        3'd5: s <= 32'(prod >> 14);
        default: begin
          if (rounded > 17'd16384) begin
            value <= neg ? -16'sd16384 : 16'sd16384;
          end else begin
            value <= neg ? -$signed(16'(rounded)) : $signed(16'(rounded));
          end
        end
      endcase
    end
  end

endmodule

[rtl/rcch_div.sv]
// ----------------------------------------------------------------------------
// rcch_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcch_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem, quot[NUM_W-1]};
  assign take   = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d    <= den;
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= take ? DEN_W'(rem_sh - {1'b0, d}) : DEN_W'(rem_sh);
      quot <= {quot[NUM_W-2:0], take};
    end
  end

endmodule

[rtl/rcch_ctrl.sv]
// ----------------------------------------------------------------------------
// rcch_ctrl
// Sequencer: map clear, cell writes, angle, sines, march, height, result.
// ----------------------------------------------------------------------------
module rcch_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  rcch_pkg::stat_t stat,
  output rcch_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADIV_GO = 4'd2;
  localparam logic [3:0] S_ADIV_W  = 4'd3;
  localparam logic [3:0] S_SIN_GO  = 4'd4;
  localparam logic [3:0] S_SIN_W   = 4'd5;
  localparam logic [3:0] S_MRD     = 4'd6;
  localparam logic [3:0] S_MCHK    = 4'd7;
  localparam logic [3:0] S_DEN     = 4'd8;
  localparam logic [3:0] S_HDIV_GO = 4'd9;
  localparam logic [3:0] S_HDIV_W  = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] sidx, sidx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sidx  <= rcch_pkg::SEL_COS;
    end else begin
      state <= state_next;
      sidx  <= sidx_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    sidx_next  = sidx;
    cmd.sine_sel = sidx;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_mode) begin
            cmd.item_latch = 1'b1;
            state_next = S_ADIV_GO;
          end else begin
            cmd.map_wr = 1'b1;
          end
        end
      end
      S_ADIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rcch_pkg::DIV_ANGLE;
        state_next    = S_ADIV_W;
      end
      S_ADIV_W: begin
        if (stat.div_done) begin
          cmd.ang_load = 1'b1;
          sidx_next    = rcch_pkg::SEL_COS;
          state_next   = S_SIN_GO;
        end
      end
      S_SIN_GO: begin
        cmd.sine_start = 1'b1;
        state_next     = S_SIN_W;
      end
      S_SIN_W: begin
        if (stat.sine_done) begin
          cmd.sine_store = 1'b1;
          if (sidx == rcch_pkg::SEL_FIX) begin
            cmd.march_init = 1'b1;
            state_next     = S_MRD;
          end else begin
            sidx_next  = sidx + 2'd1;
            state_next = S_SIN_GO;
          end
        end
      end
      S_MRD: begin
        cmd.march_rd = 1'b1;
        state_next   = S_MCHK;
      end
      S_MCHK: begin
        if (stat.wall) begin
          cmd.hit_store = 1'b1;
          state_next    = S_DEN;
        end else if (stat.last_step) begin
          cmd.miss_store = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.march_adv = 1'b1;
          state_next    = S_MRD;
        end
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        state_next   = S_HDIV_GO;
      end
      S_HDIV_GO: begin
        if (stat.den_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = rcch_pkg::DIV_HEIGHT;
          state_next    = S_HDIV_W;
        end else begin
          cmd.ht_sat = 1'b1;
          state_next = S_OUT;
        end
      end
      S_HDIV_W: begin
        if (stat.div_done) begin
          cmd.ht_div_load = 1'b1;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[rtl/rcch_dp.sv]
// ----------------------------------------------------------------------------
// rcch_dp
// Datapath: config registers, wall map, march walkers, height math, result.
// ----------------------------------------------------------------------------
module rcch_dp #(
  parameter int MAP_W           = 16,
  parameter int MAP_H           = 16,
  parameter int MAX_STEPS       = 226,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [rcch_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  logic [3:0]            in_cell_x,
  input  logic [3:0]            in_cell_y,
  input  logic                  in_cell_wall,
  input  logic [9:0]            in_ray_index,
  input  logic                  out_ready,
  input  rcch_pkg::cmd_t        cmd,
  output rcch_pkg::stat_t       stat,
  output logic                  out_valid,
  output logic [9:0]            column_index,
  output logic                  wall_hit,
  output logic [7:0]            hit_steps,
  output logic [3:0]            hit_cell_x,
  output logic [3:0]            hit_cell_y,
  output logic [11:0]           wall_height,
  output logic [10:0]           first_row,
  output logic [10:0]           end_row
);

  localparam int CELLS = MAP_W * MAP_H;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(MAX_STEPS);
  localparam int SXW   = ((NW + 16 > 24) ? NW + 16 : 24) + 2;
  localparam int VW    = SXW - 16;
  localparam int QW    = VW - 4;
  localparam int DEN_W = NW + 15;
  localparam int NUMW  = rcch_pkg::DIV_NUM_W;

  // configuration
  logic [11:0] player_x, player_y;
  logic [15:0] view_angle;
  logic [14:0] field_of_view;
  logic [10:0] ray_count, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= 12'd885;
      player_y      <= 12'd600;
      view_angle    <= 16'd15886;
      field_of_view <= 15'd10923;
      ray_count     <= 11'd512;
      screen_height <= 11'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcch_pkg::REG_PLAYER_X:      player_x      <= cfg_data[11:0];
        rcch_pkg::REG_PLAYER_Y:      player_y      <= cfg_data[11:0];
        rcch_pkg::REG_VIEW_ANGLE:    view_angle    <= cfg_data[15:0];
        rcch_pkg::REG_FIELD_OF_VIEW: field_of_view <= cfg_data[14:0];
        rcch_pkg::REG_RAY_COUNT:     ray_count     <= cfg_data[10:0];
        rcch_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // wall map with clearing sweep after reset
  logic          mem [CELLS];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] cell_addr;
  logic          cell_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] raddr;
  logic          rdata;

  assign cell_addr = AW'(32'(in_cell_y) * MAP_W + 32'(in_cell_x));
  assign cell_ok   = (32'(in_cell_x) < MAP_W) && (32'(in_cell_y) < MAP_H);
  assign mem_we    = cmd.clr_en || (cmd.map_wr && cell_ok);
  assign mem_waddr = cmd.clr_en ? clr_addr : cell_addr;
  assign mem_wdata = cmd.clr_en ? 1'b0 : in_cell_wall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.march_rd) rdata <= mem[raddr];
  end

  // angle division and sine unit
  logic [9:0]             idx;
  logic [15:0]            ang;
  logic                   div_start;
  logic [NUMW-1:0]        div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  logic [NUMW-1:0]        quot;
  logic [DEN_W-1:0]       den;
  logic                   den_pos;
  logic [15:0]            sine_arg;
  logic                   sine_done;
  logic signed [15:0]     sine_val;
  logic signed [15:0]     cs, sn, cf;

  assign div_start = cmd.div_start;
  always_comb begin
    if (cmd.div_sel == rcch_pkg::DIV_HEIGHT) begin
      div_num = NUMW'(32'(screen_height) * rcch_pkg::HEIGHT_SCALE);
      div_den = den;
    end else begin
      div_num = NUMW'(32'(field_of_view) * 32'(idx));
      div_den = (ray_count == 11'd0) ? DEN_W'(1) : DEN_W'(ray_count);
    end
  end

  rcch_div #(.NUM_W(NUMW), .DEN_W(DEN_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (quot)
  );

  // cosine arguments are a quarter turn ahead
  always_comb begin
    case (cmd.sine_sel)
      rcch_pkg::SEL_COS: sine_arg = ang + 16'd16384;
      rcch_pkg::SEL_SIN: sine_arg = ang;
      default:           sine_arg = ang - view_angle + 16'd16384;
    endcase
  end

  rcch_sine #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_sine (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.sine_start),
    .angle(sine_arg),
    .done (sine_done),
    .value(sine_val)
  );

  always_ff @(posedge clk) begin
    if (cmd.item_latch) idx <= in_ray_index;
    if (cmd.ang_load) ang <= view_angle - 16'(field_of_view >> 1) + quot[15:0];
    if (cmd.sine_store) begin
      case (cmd.sine_sel)
        rcch_pkg::SEL_COS: cs <= sine_val;
        rcch_pkg::SEL_SIN: sn <= sine_val;
        default:           cf <= sine_val;
      endcase
    end
  end

  // march walkers, coordinates scaled by 655360 per cell
  logic signed [SXW-1:0] sx, sy, dsx, dsy;
  logic [NW-1:0]         n;
  logic [VW+11:0]        prod_x, prod_y;
  logic [QW-1:0]         gx, gy;
  logic                  in_map;
  logic                  in_map_r;
  logic [3:0]            hx, hy;

  assign prod_x = (VW+12)'(sx[SXW-2:16]) * (VW+12)'(6554);
  assign prod_y = (VW+12)'(sy[SXW-2:16]) * (VW+12)'(6554);
  assign gx     = prod_x[VW+11:16];
  assign gy     = prod_y[VW+11:16];
  assign in_map = !sx[SXW-1] && !sy[SXW-1] && (32'(gx) < MAP_W) && (32'(gy) < MAP_H);
  assign raddr  = AW'(32'(gy) * MAP_W + 32'(gx));

  always_ff @(posedge clk) begin
    if (cmd.march_init) begin
      sx  <= SXW'(32'(player_x) * 2560);
      sy  <= SXW'(32'(player_y) * 2560);
      dsx <= SXW'(cs) <<< 2;
      dsy <= SXW'(sn) <<< 2;
      n   <= '0;
    end else if (cmd.march_adv) begin
      sx <= sx + dsx;
      sy <= sy + dsy;
      n  <= n + NW'(1);
    end
    if (cmd.march_rd) begin
      in_map_r <= in_map;
      if (sx[SXW-1])               hx <= 4'd0;
      else if (32'(gx) >= MAP_W)   hx <= 4'(MAP_W - 1);
      else                         hx <= gx[3:0];
      if (sy[SXW-1])               hy <= 4'd0;
      else if (32'(gy) >= MAP_H)   hy <= 4'(MAP_H - 1);
      else                         hy <= gy[3:0];
    end
  end

  // height and rows
  logic        hit;
  logic [11:0] ht;
  logic signed [12:0] top;
  logic signed [13:0] bot;
  logic [10:0] first_c, end_c;

  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den     <= DEN_W'(32'(n) * 32'(cf[14:0]));
      den_pos <= (n != '0) && (cf > 16'sd0);
    end
    if (cmd.ht_sat) ht <= rcch_pkg::HEIGHT_MAX;
    if (cmd.ht_div_load) begin
      ht <= (quot > NUMW'(rcch_pkg::HEIGHT_MAX)) ? rcch_pkg::HEIGHT_MAX : quot[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) hit <= 1'b0;
    else if (cmd.hit_store) hit <= 1'b1;
    else if (cmd.miss_store) hit <= 1'b0;
  end

  assign top = $signed({3'b0, screen_height[10:1]}) - $signed({2'b0, ht[11:1]});
  assign bot = 14'(top) + $signed({2'b0, ht});

  always_comb begin
    if (top < 13'sd0) first_c = 11'd0;
    else if (top > $signed({2'b0, screen_height})) first_c = screen_height;
    else first_c = top[10:0];
    if (bot < 14'sd0) end_c = 11'd0;
    else if (bot > $signed({3'b0, screen_height})) end_c = screen_height;
    else end_c = bot[10:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      column_index <= idx;
      wall_hit     <= hit;
      hit_steps    <= hit ? 8'(n) : 8'd0;
      hit_cell_x   <= hit ? hx : 4'd0;
      hit_cell_y   <= hit ? hy : 4'd0;
      wall_height  <= hit ? ht : 12'd0;
      first_row    <= hit ? first_c : 11'd0;
      end_row      <= hit ? end_c : 11'd0;
    end
  end

  always_comb begin
    stat.in_valid   = in_valid;
    stat.in_mode    = in_mode;
    stat.clear_last = (32'(clr_addr) == CELLS - 1);
    stat.div_done   = div_done;
    stat.sine_done  = sine_done;
    stat.wall       = !in_map_r || rdata;
    stat.last_step  = (32'(n) == MAX_STEPS - 1);
    stat.den_pos    = den_pos;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

[rtl/raycast_column_height_core.sv]
// ----------------------------------------------------------------------------
// raycast_column_height_core
// Grid ray-marching raycaster: one wall column per cast ray.
// ----------------------------------------------------------------------------
//  channel  dir  transfer when        payload
//  cfg      in   cfg_we high          cfg_index, cfg_data
//  in_ch    in   valid & ready        mode, cell_x, cell_y, cell_wall, ray_index
//  out_ch   out  valid & ready        column index, hit, steps, cell, height, rows
//
//  a cell write is taken in the idle state, which stays ready; a cast loads its
//  result after the angle division, three sine evaluations on one multiplier,
//  a map read and check per march step and, on a hit with a positive height
//  denominator, the height division; in_ch is ready again in the cycle after the load
//  after reset the map is swept clear with in_ch not ready
//  a finished result waits in the output register; the next item is taken
//  while it waits, and a cast stalls only when it must load a new result
// ----------------------------------------------------------------------------
module raycast_column_height_core #(
  parameter int MAP_W           = 16,
  parameter int MAP_H           = 16,
  parameter int MAX_STEPS       = 226,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [rcch_pkg::CFG_DATA_W-1:0] cfg_data,
  rcch_in_if.sink                         in_ch,
  rcch_out_if.source                      out_ch
);

  rcch_pkg::cmd_t  cmd;
  rcch_pkg::stat_t stat;

  assign in_ch.ready = cmd.in_ready;

  rcch_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  rcch_dp #(
    .MAP_W          (MAP_W),
    .MAP_H          (MAP_H),
    .MAX_STEPS      (MAX_STEPS),
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_ch.valid),
    .in_mode     (in_ch.mode),
    .in_cell_x   (in_ch.cell_x),
    .in_cell_y   (in_ch.cell_y),
    .in_cell_wall(in_ch.cell_wall),
    .in_ray_index(in_ch.ray_index),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .column_index(out_ch.column_index),
    .wall_hit    (out_ch.wall_hit),
    .hit_steps   (out_ch.hit_steps),
    .hit_cell_x  (out_ch.hit_cell_x),
    .hit_cell_y  (out_ch.hit_cell_y),
    .wall_height (out_ch.wall_height),
    .first_row   (out_ch.first_row),
    .end_row     (out_ch.end_row)
  );

endmodule

[dv/rcch_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcch_tb_if
// Channel interfaces for the raycaster column core testbench.
// ----------------------------------------------------------------------------
// the testbench instantiates the channel interfaces of the rtl folder, so the
// core and the testbench share one definition of each channel

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Raycaster column core testbench: map writes and ray casts are driven in
// random bursts, each cast is predicted by a bit-exact column model and the
// returned columns are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic       mode;
    logic [3:0] cx;
    logic [3:0] cy;
    logic       wall;
    logic [9:0] idx;
  } cmd_item_t;

  typedef struct packed {
    logic [9:0]  col;
    logic        hit;
    logic [7:0]  steps;
    logic [3:0]  hx;
    logic [3:0]  hy;
    logic [11:0] height;
    logic [10:0] first;
    logic [10:0] last;
  } column_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [rcch_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rcch_in_if in_ch ();
  rcch_out_if out_ch ();

  raycast_column_height_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  bit        grid [256];
  bit [11:0] pos_x, pos_y;
  bit [15:0] heading;
  bit [14:0] fov;
  bit [10:0] rays, rows;

  cmd_item_t pending_q[$];
  column_t   column_q[$];
  int        errors = 0;
  longint    cycle = 0;
  bit        stall_src = 0;
  bit        stall_sink = 0;
  bit        in_taken = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 64'd4000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint quarter_sine(longint unsigned r);
    longint unsigned z, z2, s;
    z = r << 16;
    z2 = (z * z) >> 30;
    s = 172272;
    s = 5026995 - ((s * z2) >> 30);
    s = 85569306 - ((s * z2) >> 30);
    s = 693598668 - ((s * z2) >> 30);
    s = 1686629713 - ((s * z2) >> 30);
    s = (s * z) >> 30;
    s = (s + 32768) >> 16;
    if (s > 16384) s = 16384;
    return longint'(s);
  endfunction

  function automatic longint sine_of(bit [15:0] a);
    longint unsigned k, p, q, r;
    longint v;
    k = (longint'(a) * 1024) >> 16;
    p = (k * 65536) / 1024;
    q = (p >> 14) & 3;
    r = p & 16'h3fff;
    v = q[0] ? quarter_sine(16384 - r) : quarter_sine(r);
    return q[1] ? -v : v;
  endfunction

  function automatic longint cell_of(longint scaled);
    if (scaled < 0) return -1;
    return scaled / 655360;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic column_t cast_column(bit [9:0] idx);
    column_t c;
    longint rc, cs, sn, gx, gy, den, ht, top, h;
    bit [15:0] ang;
    c = '0;
    c.col = idx;
    rc = (rays == 0) ? 1 : rays;
    ang = 16'(longint'(heading) - (fov >> 1) + (longint'(fov) * idx) / rc);
    cs = sine_of(ang + 16'd16384);
    sn = sine_of(ang);
    h = rows;
    for (longint n = 0; n < 226; n++) begin
      gx = cell_of(longint'(pos_x) * 2560 + 4 * n * cs);
      gy = cell_of(longint'(pos_y) * 2560 + 4 * n * sn);
      if (gx >= 0 && gx < 16 && gy >= 0 && gy < 16 && !grid[gy * 16 + gx]) continue;
      den = n * sine_of(16'(ang - heading) + 16'd16384);
      ht = 4095;
      if (den > 0) begin
        ht = (h * 163840) / den;
        if (ht > 4095) ht = 4095;
      end
      top = h / 2 - ht / 2;
      c.hit = 1;
      c.steps = n[7:0];
      c.hx = 4'(clampv(gx, 0, 15));
      c.hy = 4'(clampv(gy, 0, 15));
      c.height = 12'(ht);
      c.first = 11'(clampv(top, 0, h));
      c.last = 11'(clampv(top + ht, 0, h));
      break;
    end
    return c;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // transfer seen at the last rising edge
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
  end

  // driver: bursts, with random gaps when the source stalls
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 0;
      end else if (pending_q.size() != 0) begin
        cmd_item_t it;
        it = pending_q.pop_front();
        in_ch.valid <= 1;
        in_ch.mode <= it.mode;
        in_ch.cell_x <= it.cx;
        in_ch.cell_y <= it.cy;
        in_ch.cell_wall <= it.wall;
        in_ch.ray_index <= it.idx;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          if (stall_src) gap_left <= $urandom_range(0, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 37;
    if (!stall_sink) out_ch.ready <= 1;
    else out_ch.ready <= (stall_phase < 20) ? ($urandom_range(0, 3) != 0)
                                            : (stall_phase > 30);
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (in_ch.mode) column_q.push_back(cast_column(in_ch.ray_index));
      else grid[{in_ch.cell_y, in_ch.cell_x}] = in_ch.cell_wall;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (column_q.size() == 0) begin
        report("unexpected column", out_ch.column_index, -1);
      end else begin
        column_t w;
        w = column_q.pop_front();
        if (out_ch.column_index !== w.col) report("column_index", out_ch.column_index, w.col);
        if (out_ch.wall_hit !== w.hit) report("wall_hit", out_ch.wall_hit, w.hit);
        if (out_ch.hit_steps !== w.steps) report("hit_steps", out_ch.hit_steps, w.steps);
        if (out_ch.hit_cell_x !== w.hx) report("hit_cell_x", out_ch.hit_cell_x, w.hx);
        if (out_ch.hit_cell_y !== w.hy) report("hit_cell_y", out_ch.hit_cell_y, w.hy);
        if (out_ch.wall_height !== w.height)
          report("wall_height", out_ch.wall_height, w.height);
        if (out_ch.first_row !== w.first) report("first_row", out_ch.first_row, w.first);
        if (out_ch.end_row !== w.last) report("end_row", out_ch.end_row, w.last);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      rcch_pkg::REG_PLAYER_X:      pos_x = val[11:0];
      rcch_pkg::REG_PLAYER_Y:      pos_y = val[11:0];
      rcch_pkg::REG_VIEW_ANGLE:    heading = val;
      rcch_pkg::REG_FIELD_OF_VIEW: fov = val[14:0];
      rcch_pkg::REG_RAY_COUNT:     rays = val[10:0];
      default:                     rows = val[10:0];
    endcase
  endtask

  task automatic push_cell(int x, int y, bit w);
    pending_q.push_back({1'b0, 4'(x), 4'(y), w, 10'($urandom)});
  endtask

  task automatic push_ray(int i);
    pending_q.push_back({1'b1, 4'($urandom), 4'($urandom), 1'($urandom), 10'(i)});
  endtask

  // waits until all items are in and all columns out, then lets the core settle
  task automatic drain();
    while (pending_q.size() != 0 || in_ch.valid || column_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 2) == 0);
      else if ($urandom_range(0, 5) == 0) push_ray($urandom_range(0, 1023));
      else push_ray($urandom_range(0, (rays == 0) ? 0 : rays - 1));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.cell_x = 0;
    in_ch.cell_y = 0;
    in_ch.cell_wall = 0;
    in_ch.ray_index = 0;
    out_ch.ready = 1;
    foreach (grid[i]) grid[i] = 0;
    pos_x = 885; pos_y = 600; heading = 15886; fov = 10923; rays = 512; rows = 512;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty map casts, cell extremes, wall at the viewer, out-of-map rays
    push_ray(0); push_ray(511); push_ray(1023);
    push_cell(0, 0, 1); push_cell(15, 15, 1); push_cell(15, 0, 1); push_cell(0, 15, 1);
    push_cell(3, 2, 1); push_ray(256); push_ray(0);
    push_cell(3, 2, 0); push_ray(256); push_ray(100);
    drain();
    write_reg(rcch_pkg::REG_RAY_COUNT, 0);
    write_reg(rcch_pkg::REG_SCREEN_HEIGHT, 1024);
    write_reg(rcch_pkg::REG_FIELD_OF_VIEW, 32767);
    push_ray(0); push_ray(1023); push_ray(5);
    drain();
    // heading one step short of zero, wall under the viewer
    write_reg(rcch_pkg::REG_PLAYER_X, 4095);
    write_reg(rcch_pkg::REG_PLAYER_Y, 0);
    write_reg(rcch_pkg::REG_VIEW_ANGLE, 65535);
    write_reg(rcch_pkg::REG_RAY_COUNT, 1024);
    write_reg(rcch_pkg::REG_SCREEN_HEIGHT, 1);
    push_ray(0); push_ray(512); push_ray(1023);
    push_cell(15, 0, 0); push_ray(512);
    drain();
    write_reg(rcch_pkg::REG_FIELD_OF_VIEW, 0);
    write_reg(rcch_pkg::REG_VIEW_ANGLE, 0);
    write_reg(rcch_pkg::REG_PLAYER_X, 0);
    push_ray(7); push_ray(9);
    drain();

    // random phases with random settings, extremes mixed in
    for (int ph = 0; ph < 9; ph++) begin
      stall_src = ph[0];
      stall_sink = ph[1] | ph[2];
      write_reg(rcch_pkg::REG_PLAYER_X, (ph == 3) ? 0 : $urandom_range(256, 3839));
      write_reg(rcch_pkg::REG_PLAYER_Y, (ph == 4) ? 4095 : $urandom_range(256, 3839));
      write_reg(rcch_pkg::REG_VIEW_ANGLE, $urandom_range(0, 65535));
      write_reg(rcch_pkg::REG_FIELD_OF_VIEW, (ph == 5) ? 32767 : $urandom_range(0, 20000));
      write_reg(rcch_pkg::REG_RAY_COUNT, (ph == 6) ? 1 : $urandom_range(1, 1024));
      write_reg(rcch_pkg::REG_SCREEN_HEIGHT, (ph == 7) ? 1024 : $urandom_range(1, 1024));
      random_phase(200);
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
